// ===== sv/sample_silence_trim_detector_defines.svh =====
// assertion macros for the silence trim detector
// used by the top level, no other dependencies
`ifndef SAMPLE_SILENCE_TRIM_DETECTOR_DEFINES_SVH
`define SAMPLE_SILENCE_TRIM_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SSTD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sstd assertion failed");
// next-cycle implication
`define SSTD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sstd assertion failed");
`else
`define SSTD_ASSERT_IMP(label, clk, rst, ante, cons)
`define SSTD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== sv/sstd_pkg.sv =====
// shared constants, types and helpers for the silence trim detector
// no dependencies
package sstd_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int FRAME_BITS  = 24;
  localparam int SAMPLE_BITS = 16;
  localparam int ENERGY_BITS = 2 * SAMPLE_BITS;
  localparam int SUM_BITS    = 38;
  localparam int WLEN_BITS   = 7;
  localparam int HEAD_BITS   = 38;
  localparam int TAIL_BITS   = 32;
  localparam int MARGIN_BITS = 24;
  localparam int OUT_BITS    = 24;

  localparam int POS_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_BITS  = $clog2(MAX_WINDOW + 1);
  localparam int CALC_BITS = ((FRAME_BITS > MARGIN_BITS) ? FRAME_BITS : MARGIN_BITS) + 2;

  // last frame index the counter reaches before it saturates
  localparam logic [FRAME_BITS-1:0] FRAME_MAX_IDX = {{(FRAME_BITS-1){1'b1}}, 1'b0};

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 38;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEREO_MODE    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEAD_THRESHOLD = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TAIL_THRESHOLD = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TAIL_MARGIN    = 3'd4;

  typedef struct packed {
    logic                   stereo_mode;
    logic [WLEN_BITS-1:0]   window_length;
    logic [HEAD_BITS-1:0]   head_threshold;
    logic [TAIL_BITS-1:0]   tail_threshold;
    logic [MARGIN_BITS-1:0] margin_len;
  } cfg_t;

  // one classified frame between front and back
  typedef struct packed {
    logic [ENERGY_BITS-1:0] energy;
    logic                   loud;
    logic                   last;
  } qent_t;

  typedef struct packed {
    logic [QPTR_BITS:0] count;
  } qstat_t;

  typedef struct packed {
    logic fire_last;
    logic ring_any;
  } bstat_t;

  // window length as used: zero acts as one, clamp to the ring size
  function automatic logic [WIN_BITS-1:0] eff_window(input logic [WLEN_BITS-1:0] wl);
    logic [31:0]         wide;
    logic [WIN_BITS-1:0] res;
    wide = 32'(wl);
    if (wide == 32'd0) begin
      res = WIN_BITS'(1);
    end else if (wide > 32'(MAX_WINDOW)) begin
      res = WIN_BITS'(MAX_WINDOW);
    end else begin
      res = WIN_BITS'(wide);
    end
    return res;
  endfunction

endpackage

// ===== sv/sstd_if.sv =====
// stream interfaces for frames, trim results and register writes
// depends on sstd_pkg
interface sstd_in_if;
  import sstd_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic                          last_frame;
  modport source(output valid, left_sample, right_sample, last_frame, input ready);
  modport sink(input valid, left_sample, right_sample, last_frame, output ready);
endinterface

interface sstd_out_if;
  import sstd_pkg::*;
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] trim_start;
  logic [OUT_BITS-1:0] trim_end;
  modport source(output valid, trim_start, trim_end, input ready);
  modport sink(input valid, trim_start, trim_end, output ready);
endinterface

interface sstd_cfg_if;
  import sstd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/sstd_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module sstd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ===== sv/sstd_front.sv =====
// front end: accepts frames, squares the samples, classifies loudness
// depends on sstd_pkg and sstd_if
module sstd_front (
  input  logic          clk,
  input  logic          rst,
  sstd_in_if.sink       samples,
  input  sstd_pkg::cfg_t cfg_regs,
  output logic          push_valid,
  input  logic          push_ready,
  output sstd_pkg::qent_t push_data
);
  import sstd_pkg::*;

  logic                          f_valid;
  logic                          f_last;
  logic [ENERGY_BITS-1:0]        sq_left;
  logic [ENERGY_BITS-1:0]        sq_right;
  logic signed [ENERGY_BITS-1:0] prod_left;
  logic signed [ENERGY_BITS-1:0] prod_right;
  logic [ENERGY_BITS-1:0]        energy;
  logic                          accept;

  assign prod_left  = samples.left_sample * samples.left_sample;
  assign prod_right = samples.right_sample * samples.right_sample;

  assign samples.ready = !f_valid || push_ready;
  assign accept        = samples.valid && samples.ready;

  // squares register
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (samples.ready) begin
      f_valid <= samples.valid;
    end
    if (accept) begin
      sq_left  <= $unsigned(prod_left);
      sq_right <= cfg_regs.stereo_mode ? $unsigned(prod_right) : '0;
      f_last   <= samples.last_frame;
    end
  end

  // frame energy and loudness toward the queue
  assign energy               = sq_left + sq_right;
  assign push_valid           = f_valid;
  assign push_data.energy     = energy;
  assign push_data.loud       = energy > cfg_regs.tail_threshold;
  assign push_data.last       = f_last;

endmodule

// ===== sv/sstd_queue.sv =====
// short fifo of classified frames between front and back
// depends on sstd_pkg
module sstd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  sstd_pkg::qent_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output sstd_pkg::qent_t pop_data,
  output sstd_pkg::qstat_t q_stat
);
  import sstd_pkg::*;

  qent_t              slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = count != (QPTR_BITS + 1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];
  assign q_stat.count = count;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/sstd_back.sv =====
// back end: energy ring, window sum, onset and tail tracking, trim result
// depends on sstd_pkg, sstd_if and sstd_ram
module sstd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  sstd_pkg::qent_t  pop_data,
  input  sstd_pkg::cfg_t   cfg_regs,
  sstd_out_if.source       trims,
  output sstd_pkg::bstat_t b_stat
);
  import sstd_pkg::*;

  logic [WIN_BITS-1:0] w_eff;

  // ring position and frame index, advanced as frames enter
  logic [POS_BITS-1:0]   ring_position;
  logic [FRAME_BITS-1:0] frame_counter;
  logic [POS_BITS-1:0]   pos_cur;
  logic [POS_BITS-1:0]   pos_inc;
  logic                  accept;

  // read stage
  logic                   s1_valid;
  logic [ENERGY_BITS-1:0] s1_energy;
  logic                   s1_loud;
  logic                   s1_last;
  logic [POS_BITS-1:0]    s1_pos;
  logic [FRAME_BITS-1:0]  s1_idx;
  logic                   s1_fwd;
  logic [ENERGY_BITS-1:0] s1_fwd_e;
  logic                   s1_free;
  logic [ENERGY_BITS-1:0] ram_rd;

  // update stage state
  logic [MAX_WINDOW-1:0]  ring_valid;
  logic [SUM_BITS-1:0]    window_sum;
  logic                   onset_found;
  logic [FRAME_BITS-1:0]  onset_frame;
  logic                   loud_seen;
  logic [FRAME_BITS-1:0]  last_loud_frame;
  logic [ENERGY_BITS-1:0] old_e;
  logic [SUM_BITS-1:0]    sum_next;
  logic                   onset_hit;
  logic                   s2_fire;
  logic [FRAME_BITS-1:0]  len_cur;

  // result stage
  logic                  r_valid;
  logic [FRAME_BITS-1:0] r_onset;
  logic                  r_loud_seen;
  logic [FRAME_BITS-1:0] r_loud;
  logic [FRAME_BITS-1:0] r_len;
  logic                  r_free;
  logic                  r_move;

  // output register
  logic                out_valid;
  logic [OUT_BITS-1:0] out_start;
  logic [OUT_BITS-1:0] out_end;
  logic                o_free;

  logic signed [CALC_BITS-1:0] len_s;
  logic signed [CALC_BITS-1:0] start_raw;
  logic signed [CALC_BITS-1:0] start_c;
  logic signed [CALC_BITS-1:0] loud_s;
  logic signed [CALC_BITS-1:0] keep_s;
  logic signed [CALC_BITS-1:0] end_raw;
  logic signed [CALC_BITS-1:0] end_c;

  assign w_eff = eff_window(cfg_regs.window_length);

  // handshake chain, back to front
  assign o_free    = !out_valid || trims.ready;
  assign r_move    = r_valid && o_free;
  assign r_free    = !r_valid || r_move;
  assign s2_fire   = s1_valid && (!s1_last || r_free);
  assign s1_free   = !s1_valid || s2_fire;
  assign pop_ready = s1_free;
  assign accept    = pop_valid && s1_free;

  // slot for this frame, wrapping when the window shrank
  always_comb begin
    pos_cur = (32'(ring_position) >= 32'(w_eff)) ? '0 : ring_position;
    pos_inc = (32'(pos_cur) + 32'd1 >= 32'(w_eff)) ? '0 : POS_BITS'(32'(pos_cur) + 32'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_position <= '0;
      frame_counter <= '0;
      s1_valid      <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= pop_valid;
      end
      if (accept) begin
        if (pop_data.last) begin
          ring_position <= '0;
          frame_counter <= '0;
        end else begin
          ring_position <= pos_inc;
          if (frame_counter < FRAME_MAX_IDX) begin
            frame_counter <= frame_counter + 1'b1;
          end
        end
      end
    end
  end

  // read stage payload, bypass when the frame ahead writes the same slot
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_energy <= pop_data.energy;
      s1_loud   <= pop_data.loud;
      s1_last   <= pop_data.last;
      s1_pos    <= pos_cur;
      s1_idx    <= frame_counter;
      s1_fwd    <= s2_fire && (s1_pos == pos_cur);
      s1_fwd_e  <= s1_energy;
    end
  end

  sstd_ram #(
    .WIDTH(ENERGY_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk    (clk),
    .wr_en  (s2_fire),
    .wr_addr(s1_pos),
    .wr_data(s1_energy),
    .rd_en  (accept),
    .rd_addr(pos_cur),
    .rd_data(ram_rd)
  );

  // window sum update and onset test
  always_comb begin
    if (!ring_valid[s1_pos]) begin
      old_e = '0;
    end else if (s1_fwd) begin
      old_e = s1_fwd_e;
    end else begin
      old_e = ram_rd;
    end
    sum_next  = window_sum - SUM_BITS'(old_e) + SUM_BITS'(s1_energy);
    onset_hit = !onset_found && (sum_next > cfg_regs.head_threshold);
    len_cur   = s1_idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid  <= '0;
      window_sum  <= '0;
      onset_found <= 1'b0;
      loud_seen   <= 1'b0;
    end else if (s2_fire) begin
      if (s1_last) begin
        ring_valid  <= '0;
        window_sum  <= '0;
        onset_found <= 1'b0;
        loud_seen   <= 1'b0;
      end else begin
        ring_valid[s1_pos] <= 1'b1;
        window_sum         <= sum_next;
        onset_found        <= onset_found || onset_hit;
        loud_seen          <= loud_seen || s1_loud;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && onset_hit) begin
      onset_frame <= s1_idx;
    end
    if (s2_fire && s1_loud) begin
      last_loud_frame <= s1_idx;
    end
  end

  // result stage capture on the last frame
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (s2_fire && s1_last) begin
      r_valid <= 1'b1;
    end else if (r_move) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && s1_last) begin
      if (onset_found) begin
        r_onset <= onset_frame;
      end else if (onset_hit) begin
        r_onset <= s1_idx;
      end else begin
        r_onset <= len_cur;
      end
      r_loud_seen <= loud_seen || s1_loud;
      r_loud      <= s1_loud ? s1_idx : last_loud_frame;
      r_len       <= len_cur;
    end
  end

  // trim range from onset, last loud frame and tail margin
  always_comb begin
    len_s     = $signed(CALC_BITS'(r_len));
    start_raw = $signed(CALC_BITS'(r_onset)) - $signed(CALC_BITS'(w_eff));
    if (start_raw < 0) begin
      start_c = '0;
    end else if (start_raw > len_s - CALC_BITS'(1)) begin
      start_c = len_s - CALC_BITS'(1);
    end else begin
      start_c = start_raw;
    end
    loud_s  = r_loud_seen ? $signed(CALC_BITS'(r_loud)) : CALC_BITS'(-1);
    keep_s  = len_s - $signed(CALC_BITS'(cfg_regs.margin_len));
    end_raw = ((loud_s > keep_s) ? loud_s : keep_s) + CALC_BITS'(1);
    if (end_raw < 1) begin
      end_c = CALC_BITS'(1);
    end else if (end_raw > len_s) begin
      end_c = len_s;
    end else begin
      end_c = end_raw;
    end
    if (end_c <= start_c) begin
      end_c = len_s;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_free) begin
      out_valid <= r_valid;
    end
    if (r_move) begin
      out_start <= OUT_BITS'($unsigned(start_c));
      out_end   <= OUT_BITS'($unsigned(end_c));
    end
  end

  assign trims.valid      = out_valid;
  assign trims.trim_start = out_start;
  assign trims.trim_end   = out_end;

  assign b_stat.fire_last = s2_fire && s1_last;
  assign b_stat.ring_any  = |ring_valid;

endmodule

// ===== sv/sample_silence_trim_detector.sv =====
// silence trim detector top level: register file, front, queue, back
// depends on sstd_pkg, sstd_if, sstd_front, sstd_queue, sstd_back
// and the assertion macro header
//
// Usage: frames enter on the samples channel, one request per frame, with
// last_frame set on the final frame of a sample. The trims channel carries
// one request per last frame: trim_start and trim_end for that sample.
// Registers are written on the cfg channel (ready is always high) while no
// frame is in flight.
// Throughput: one frame per cycle while the trims receiver does not stall.
// The rate is set by the energy ring: a ram read in one back stage and the
// write in the next, with a bypass for a frame that hits the slot the frame
// ahead is writing. A last frame's result passes the front register, queue,
// read stage, result stage and output register. Reset clears all registers
// to their defaults and empties the ring, the queue and the pipeline. A
// stalled trims receiver holds the output; frames flow until a last frame
// waits on a full result stage and the queue and front register fill up.
module sample_silence_trim_detector (
  input logic      clk,
  input logic      rst,
  sstd_in_if.sink  samples,
  sstd_out_if.source trims,
  sstd_cfg_if.sink cfg
);
  import sstd_pkg::*;

`include "sample_silence_trim_detector_defines.svh"

  cfg_t   cfg_regs;
  qent_t  push_data;
  qent_t  pop_data;
  logic   push_valid;
  logic   push_ready;
  logic   pop_valid;
  logic   pop_ready;
  qstat_t q_stat;
  bstat_t b_stat;

  // register file
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.stereo_mode    <= 1'b0;
      cfg_regs.window_length  <= WLEN_BITS'(24);
      cfg_regs.head_threshold <= HEAD_BITS'(1288490);
      cfg_regs.tail_threshold <= TAIL_BITS'(107374);
      cfg_regs.margin_len     <= MARGIN_BITS'(1152);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_STEREO_MODE:    cfg_regs.stereo_mode    <= cfg.data[0];
        REG_WINDOW_LENGTH:  cfg_regs.window_length  <= cfg.data[WLEN_BITS-1:0];
        REG_HEAD_THRESHOLD: cfg_regs.head_threshold <= cfg.data[HEAD_BITS-1:0];
        REG_TAIL_THRESHOLD: cfg_regs.tail_threshold <= cfg.data[TAIL_BITS-1:0];
        REG_TAIL_MARGIN:    cfg_regs.margin_len     <= cfg.data[MARGIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  sstd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .cfg_regs  (cfg_regs),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  sstd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  sstd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .cfg_regs (cfg_regs),
    .trims    (trims),
    .b_stat   (b_stat)
  );

  // a reported range is never empty
  `SSTD_ASSERT_IMP(a_range_nonempty, clk, rst, trims.valid, trims.trim_end > trims.trim_start)
  // the last frame of a sample leaves the ring empty
  `SSTD_ASSERT_NXT(a_ring_cleared, clk, rst, b_stat.fire_last, !b_stat.ring_any)
  // an empty queue never lets the front block the next cycle
  `SSTD_ASSERT_NXT(a_front_flows, clk, rst, q_stat.count == '0, samples.ready)

endmodule

// ===== tb/sv/sstd_trim_checker.sv =====
// trim result checker for the silence trim detector: watches all three channels,
// predicts each trim request and compares it. depends on sstd_pkg and sstd_if
module sstd_trim_checker
  import sstd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  sstd_in_if   samples,
  sstd_out_if  trims,
  sstd_cfg_if  cfg,
  output int   fail_count,
  output int   trims_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // register values after reset
  localparam logic [WLEN_BITS-1:0]   RST_WINDOW = 7'd24;
  localparam logic [HEAD_BITS-1:0]   RST_HEAD   = 38'd1288490;
  localparam logic [TAIL_BITS-1:0]   RST_TAIL   = 32'd107374;
  localparam logic [MARGIN_BITS-1:0] RST_MARGIN = 24'd1152;

  typedef struct packed {
    logic [OUT_BITS-1:0] start_frame;
    logic [OUT_BITS-1:0] end_frame;
  } trim_t;

  // register copies
  logic                   stereo_on;
  logic [WLEN_BITS-1:0]   win_len_reg;
  logic [HEAD_BITS-1:0]   head_lvl;
  logic [TAIL_BITS-1:0]   tail_lvl;
  logic [MARGIN_BITS-1:0] margin_frames;

  // per-sample state
  logic [ENERGY_BITS-1:0] frame_energy [MAX_WINDOW];
  logic [SUM_BITS-1:0]    energy_total;
  int                     slot;
  logic [FRAME_BITS-1:0]  next_frame;
  logic                   onset_seen;
  logic [FRAME_BITS-1:0]  onset_idx;
  logic                   loud_hit;
  logic [FRAME_BITS-1:0]  loud_idx;

  trim_t trim_expect_q[$];

  initial fail_count = 0;

  function automatic void restart_sample();
    foreach (frame_energy[i]) frame_energy[i] = '0;
    energy_total = '0;
    slot         = 0;
    next_frame   = '0;
    onset_seen   = 1'b0;
    onset_idx    = '0;
    loud_hit     = 1'b0;
    loud_idx     = '0;
  endfunction

  // one frame through the energy window; a last frame queues its trim range
  function automatic void predict_frame(input logic signed [SAMPLE_BITS-1:0] l, r,
                                        input logic last);
    longint unsigned       e;
    int                    w;
    int                    p;
    logic [FRAME_BITS-1:0] idx;
    longint                len, onset, trim_lo, loud, keep, trim_hi;
    trim_t                 t;
    e = longint'(l) * longint'(l);
    if (stereo_on) e += longint'(r) * longint'(r);
    w = (win_len_reg == 0) ? 1 : (win_len_reg > MAX_WINDOW) ? MAX_WINDOW : int'(win_len_reg);

    // replace the oldest slot and keep the running sum exact
    p = (slot >= w) ? 0 : slot;
    energy_total = energy_total - SUM_BITS'(frame_energy[p]) + SUM_BITS'(e);
    frame_energy[p] = e[ENERGY_BITS-1:0];
    slot = (p + 1 >= w) ? 0 : p + 1;

    idx = next_frame;
    if (!onset_seen && energy_total > head_lvl) begin
      onset_seen = 1'b1;
      onset_idx  = idx;
    end
    if (e > tail_lvl) begin
      loud_hit = 1'b1;
      loud_idx = idx;
    end
    if (next_frame < FRAME_MAX_IDX) next_frame++;

    if (last) begin
      len     = longint'(idx) + 1;
      onset   = onset_seen ? longint'(onset_idx) : len;
      trim_lo = onset - w;
      if (trim_lo < 0) trim_lo = 0;
      if (trim_lo > len - 1) trim_lo = len - 1;
      loud    = loud_hit ? longint'(loud_idx) : -1;
      keep    = len - longint'(margin_frames);
      trim_hi = ((loud > keep) ? loud : keep) + 1;
      if (trim_hi < 1) trim_hi = 1;
      if (trim_hi > len) trim_hi = len;
      if (trim_hi <= trim_lo) trim_hi = len;
      t.start_frame = trim_lo[OUT_BITS-1:0];
      t.end_frame   = trim_hi[OUT_BITS-1:0];
      trim_expect_q.push_back(t);
      restart_sample();
    end
  endfunction

  always @(posedge clk) begin
    trim_t want;
    if (rst) begin
      stereo_on     = 1'b0;
      win_len_reg   = RST_WINDOW;
      head_lvl      = RST_HEAD;
      tail_lvl      = RST_TAIL;
      margin_frames = RST_MARGIN;
      restart_sample();
      trim_expect_q.delete();
    end else begin
      // register write request
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_STEREO_MODE:    stereo_on     = cfg.data[0];
          REG_WINDOW_LENGTH:  win_len_reg   = cfg.data[WLEN_BITS-1:0];
          REG_HEAD_THRESHOLD: head_lvl      = cfg.data[HEAD_BITS-1:0];
          REG_TAIL_THRESHOLD: tail_lvl      = cfg.data[TAIL_BITS-1:0];
          REG_TAIL_MARGIN:    margin_frames = cfg.data[MARGIN_BITS-1:0];
          default: ;
        endcase
      end

      // trim request against the oldest expectation
      if (trims.valid && trims.ready) begin
        if (trim_expect_q.size() == 0) begin
          $error("unexpected trim request: trim_start %0d, trim_end %0d",
                 trims.trim_start, trims.trim_end);
          fail_count++;
        end else begin
          want = trim_expect_q.pop_front();
          if (trims.trim_start !== want.start_frame) begin
            $error("trim_start mismatch: expected %0d, actual %0d",
                   want.start_frame, trims.trim_start);
            fail_count++;
          end
          if (trims.trim_end !== want.end_frame) begin
            $error("trim_end mismatch: expected %0d, actual %0d",
                   want.end_frame, trims.trim_end);
            fail_count++;
          end
        end
      end

      // frame request
      if (samples.valid && samples.ready)
        predict_frame(samples.left_sample, samples.right_sample, samples.last_frame);
    end
    trims_pending = trim_expect_q.size();
  end

endmodule

// ===== tb/sv/tb_sample_silence_trim_detector.sv =====
// testbench top for the silence trim detector: clock, reset, frame and register
// stimulus, trims receiver stalls and verdict. depends on sstd_pkg, sstd_if,
// sstd_trim_checker and the detector rtl
module tb_sample_silence_trim_detector
  import sstd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF      = 6;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int ITEM_GOAL     = 1750;
  localparam int PHASE_ITEMS   = 160;
  localparam int SETTLE_CYCLES = 12;
  localparam logic [CFG_DATA_BITS-1:0] HEAD_MAX   = 38'h3F_FFFF_FFFF;
  localparam logic [CFG_DATA_BITS-1:0] TAIL_MAX   = 38'h00_FFFF_FFFF;
  localparam logic [CFG_DATA_BITS-1:0] MARGIN_MAX = 38'h00_00FF_FFFF;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_RARE, STALL_LONG} stall_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   trims_pending;
  int   frames_sent = 0;
  int   burst_left = 0;
  int   cycle_count = 0;
  stall_t stall_mode = STALL_NONE;
  int   stretch_left = 0;

  sstd_in_if  samples_if();
  sstd_out_if trims_if();
  sstd_cfg_if cfg_if();

  sample_silence_trim_detector i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .trims   (trims_if),
    .cfg     (cfg_if)
  );

  sstd_trim_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .samples       (samples_if),
    .trims         (trims_if),
    .cfg           (cfg_if),
    .fail_count    (fail_count),
    .trims_pending (trims_pending)
  );

  always #(CLK_HALF) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sample_silence_trim_detector regression: fail");
      $finish;
    end
  end

  // trims receiver: stretches of different stall behavior
  always @(negedge clk) begin
    if (stretch_left == 0) begin
      stall_mode   = stall_t'($urandom_range(0, 3));
      stretch_left = $urandom_range(8, 96);
    end else begin
      stretch_left--;
    end
    case (stall_mode)
      STALL_NONE: trims_if.ready <= 1'b1;
      STALL_COIN: trims_if.ready <= ($urandom_range(0, 1) == 1);
      STALL_RARE: trims_if.ready <= ($urandom_range(0, 7) != 0);
      default:    trims_if.ready <= ((stretch_left % 12) < 3);
    endcase
  end

  // sample value within +-amp; full scale gives any 16-bit pattern
  function automatic logic signed [SAMPLE_BITS-1:0] draw_level(input int amp);
    if (amp >= 32767) return SAMPLE_BITS'($urandom);
    return SAMPLE_BITS'(int'($urandom_range(0, 2 * amp)) - amp);
  endfunction

  // random bits above the register width, now and then
  function automatic logic [CFG_DATA_BITS-1:0] with_junk(input logic [CFG_DATA_BITS-1:0] v,
                                                         input int width);
    logic [CFG_DATA_BITS-1:0] junk;
    junk = CFG_DATA_BITS'({$urandom, $urandom});
    if ($urandom_range(0, 2) == 0) return v | (junk << width);
    return v;
  endfunction

  // one frame request; sender works in bursts with gaps between them
  task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] l, r, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        samples_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    samples_if.valid        <= 1'b1;
    samples_if.left_sample  <= l;
    samples_if.right_sample <= r;
    samples_if.last_frame   <= last;
    do @(posedge clk); while (!samples_if.ready);
    @(negedge clk);
    burst_left--;
    frames_sent++;
  endtask

  // write all five registers, one request each
  task automatic program_regs(input logic [CFG_DATA_BITS-1:0] stereo, wlen, head, tail,
                              margin);
    logic [CFG_DATA_BITS-1:0]  vals [5];
    logic [CFG_INDEX_BITS-1:0] regs [5];
    vals = '{stereo, wlen, head, tail, margin};
    regs = '{REG_STEREO_MODE, REG_WINDOW_LENGTH, REG_HEAD_THRESHOLD, REG_TAIL_THRESHOLD,
             REG_TAIL_MARGIN};
    for (int i = 0; i < 5; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= regs[i];
      cfg_if.data  <= vals[i];
      do @(posedge clk); while (!cfg_if.ready);
      @(negedge clk);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // stop frames, wait for every trim, then let the pipeline settle
  task automatic wait_drained();
    samples_if.valid <= 1'b0;
    while (trims_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int head_len, body_len, tail_len, total;
    int quiet_amp, loud_amp, amp, phase_base;
    logic [CFG_DATA_BITS-1:0] wlen_v, head_v, tail_v, margin_v;

    samples_if.valid        = 1'b0;
    samples_if.left_sample  = '0;
    samples_if.right_sample = '0;
    samples_if.last_frame   = 1'b0;
    trims_if.ready          = 1'b0;
    cfg_if.valid            = 1'b0;
    cfg_if.index            = REG_STEREO_MODE;
    cfg_if.data             = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: two one-frame samples, then a five-frame sample; full-scale and silent
    send_frame(16'sh7FFF, 16'sh8000, 1'b1);
    send_frame(16'sh0000, 16'sh7FFF, 1'b1);
    send_frame(16'sh0000, 16'sh0000, 1'b0);
    send_frame(16'sh8000, 16'sh0000, 1'b0);
    send_frame(16'shFFFF, 16'sh0001, 1'b0);
    send_frame(16'sh0001, 16'shFFFF, 1'b0);
    send_frame(16'sh7FFF, 16'sh0000, 1'b1);
    wait_drained();

    // stereo, zero window acts as one, zero thresholds and margin;
    // both channels at -1.0 give the largest energy
    program_regs(38'd1, 38'd0, 38'd0, 38'd0, 38'd0);
    send_frame(16'sh0000, 16'sh0000, 1'b0);
    send_frame(16'sh0000, 16'sh0000, 1'b0);
    send_frame(16'sh8000, 16'sh8000, 1'b0);
    send_frame(16'sh0000, 16'sh0001, 1'b0);
    send_frame(16'sh0000, 16'sh0000, 1'b1);
    wait_drained();

    // window above the ring size, all thresholds and margin at maximum
    program_regs(38'd1, 38'd127, HEAD_MAX, TAIL_MAX, MARGIN_MAX);
    send_frame(16'sh8000, 16'sh8000, 1'b0);
    send_frame(16'sh7FFF, 16'sh8000, 1'b0);
    send_frame(16'sh5555, 16'shAAAA, 1'b0);
    send_frame(16'shAAAA, 16'sh5555, 1'b1);
    wait_drained();

    // early loud frame, quiet frames cross the head later: end falls back to len
    program_regs(38'd0, 38'd2, 38'd150, 38'd100, 38'd1000);
    send_frame(16'sd11, 16'sh0000, 1'b0);
    send_frame(16'sh0000, 16'sh0000, 1'b0);
    send_frame(16'sh0000, 16'sh0000, 1'b0);
    send_frame(16'sh0000, 16'sh0000, 1'b0);
    send_frame(16'sh0000, 16'sh0000, 1'b0);
    send_frame(16'sd9, 16'sh0000, 1'b0);
    send_frame(-16'sd9, 16'sh0000, 1'b1);
    wait_drained();

    // random phases: new settings, then samples shaped quiet-loud-quiet
    for (int ph = 0; frames_sent < ITEM_GOAL; ph++) begin
      if (ph == 0) wlen_v = 38'd64;
      else if (ph == 1) wlen_v = 38'd1;
      else begin
        case ($urandom_range(0, 3))
          0:       wlen_v = CFG_DATA_BITS'($urandom_range(1, 8));
          1:       wlen_v = CFG_DATA_BITS'($urandom_range(1, 64));
          2:       wlen_v = CFG_DATA_BITS'($urandom_range(65, 127));
          default: wlen_v = 38'd0;
        endcase
      end
      case ($urandom_range(0, 5))
        0:       head_v = '0;
        1:       head_v = CFG_DATA_BITS'($urandom_range(0, 32'h0010_0000));
        2:       head_v = CFG_DATA_BITS'($urandom_range(32'h0400_0000, 32'hFFFF_FFFF));
        3:       head_v = HEAD_MAX;
        4:       head_v = CFG_DATA_BITS'({$urandom, $urandom});
        default: head_v = CFG_DATA_BITS'($urandom_range(1, 64)) << 30;
      endcase
      case ($urandom_range(0, 5))
        0:       tail_v = '0;
        1:       tail_v = CFG_DATA_BITS'($urandom_range(0, 4000));
        2:       tail_v = CFG_DATA_BITS'($urandom_range(0, 32'h0100_0000));
        3:       tail_v = 38'h00_8000_0000;
        4:       tail_v = TAIL_MAX;
        default: tail_v = CFG_DATA_BITS'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       margin_v = '0;
        1:       margin_v = CFG_DATA_BITS'($urandom_range(1, 8));
        2:       margin_v = CFG_DATA_BITS'($urandom_range(1, 64));
        3:       margin_v = MARGIN_MAX;
        default: margin_v = CFG_DATA_BITS'($urandom_range(0, 24'hFF_FFFF));
      endcase
      program_regs(with_junk(CFG_DATA_BITS'($urandom_range(0, 1)), 1),
                   with_junk(wlen_v, WLEN_BITS), head_v,
                   with_junk(tail_v, TAIL_BITS), with_junk(margin_v, MARGIN_BITS));

      phase_base = frames_sent;
      while (frames_sent - phase_base < PHASE_ITEMS && frames_sent < ITEM_GOAL) begin
        // mostly short samples, a few long ones
        if ($urandom_range(0, 9) == 0) begin
          head_len = $urandom_range(0, 90);
          body_len = $urandom_range(0, 90);
          tail_len = $urandom_range(0, 90);
        end else begin
          head_len = $urandom_range(0, 10);
          body_len = $urandom_range(0, 10);
          tail_len = $urandom_range(0, 10);
        end
        if (head_len + body_len + tail_len == 0) body_len = 1;
        total = head_len + body_len + tail_len;
        case ($urandom_range(0, 4))
          0:       quiet_amp = 0;
          1:       quiet_amp = 3;
          2:       quiet_amp = 60;
          3:       quiet_amp = 400;
          default: quiet_amp = 2000;
        endcase
        case ($urandom_range(0, 2))
          0:       loud_amp = 32767;
          1:       loud_amp = $urandom_range(1000, 32767);
          default: loud_amp = $urandom_range(50, 600);
        endcase
        for (int f = 0; f < total; f++) begin
          if (f >= head_len && f < head_len + body_len) amp = loud_amp;
          else amp = quiet_amp;
          // occasional noise frame anywhere
          if ($urandom_range(0, 15) == 0) amp = 32767;
          send_frame(draw_level(amp), draw_level(amp), f == total - 1);
        end
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("sample_silence_trim_detector regression: pass");
    end else begin
      $display("sample_silence_trim_detector regression: fail");
    end
    $finish;
  end

endmodule
